>>> rtl/vpp_pkg.sv
package vpp_pkg;

  // Field widths
  localparam int unsigned CmdW     = 2;
  localparam int unsigned WordW    = 32;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned MaskW    = 16;
  localparam int unsigned CountW   = 4;
  localparam int unsigned PeriodW  = 10;
  localparam int unsigned StepsW   = 17;

  // Pattern word layout
  localparam int unsigned CountLsb  = 26;
  localparam int unsigned PeriodLsb = 16;

  // Stream payload widths (padded to whole bytes)
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 8;

  // Command codes carried in tuser
  typedef enum logic [CmdW-1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture_in;  // register the accepted input transaction
    logic apply;       // execute stop, tick or a start that needs no division
    logic div_init;    // latch pattern and seed the divider
    logic div_step;    // one restoring-division iteration
    logic finish;      // load step budget and play the first step
    logic load_out;    // capture motor and busy into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_go;     // start command that is allowed to run
    logic period_zero;  // latched step length is zero
    logic div_last;     // final division iteration this cycle
  } dp_sts_t;

endpackage

>>> rtl/vpp_ctrl.sv
module vpp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  vpp_pkg::dp_sts_t  sts_i,
  output vpp_pkg::dp_cmd_t  cmd_o
);
  import vpp_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture_in = 1'b1;
          state_d          = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.start_go && !sts_i.period_zero) begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output slot is free or draining
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/vpp_datapath.sv
module vpp_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [vpp_pkg::CmdW-1:0]      cmd_code_i,
  input  logic [vpp_pkg::WordW-1:0]     pattern_word_i,
  input  logic [vpp_pkg::TimeoutW-1:0]  timeout_ms_i,
  input  logic                          force_req_i,
  input  logic                          in_silent_hours_i,
  input  vpp_pkg::dp_cmd_t              cmd_i,
  output vpp_pkg::dp_sts_t              sts_o,
  output logic                          motor_on_o,
  output logic                          busy_res_o
);
  import vpp_pkg::*;

  // Captured input transaction
  logic [CmdW-1:0]     code_q;
  logic [WordW-1:0]    word_q;
  logic [TimeoutW-1:0] timeout_q;
  logic                force_q;
  logic                silent_q;

  // Player state
  logic [MaskW-1:0]   mask_q;
  logic [CountW-1:0]  count_code_q;
  logic [PeriodW-1:0] period_q;
  logic [PeriodW-1:0] ms_q;
  logic [CountW-1:0]  idx_q;
  logic [StepsW-1:0]  left_q;
  logic               run_q;
  logic               motor_q;

  // Divider
  logic [PeriodW-1:0]  rem_q;
  logic [TimeoutW-1:0] quo_q;
  logic [CountW-1:0]   div_cnt_q;

  // Output register payload
  logic out_motor_q;
  logic out_busy_q;

  logic [MaskW-1:0]   word_mask;
  logic [CountW-1:0]  word_count;
  logic [PeriodW-1:0] word_period;

  logic [PeriodW:0]   div_shift;
  logic [PeriodW+1:0] div_diff;
  logic               div_ge;

  logic [StepsW-1:0]  ceil_val;
  logic [StepsW-1:0]  step_src;
  logic [StepsW-1:0]  step_left;
  logic               step_run;
  logic               step_motor;
  logic [CountW-1:0]  step_idx;
  logic [CountW:0]    idx_inc;
  logic [CountW:0]    count_eff;

  logic [PeriodW-1:0] ms_inc;

  assign word_mask   = word_q[MaskW-1:0];
  assign word_count  = word_q[CountLsb +: CountW];
  assign word_period = word_q[PeriodLsb +: PeriodW];

  assign sts_o.start_go    = (code_q == CMD_START) && (force_q || !silent_q);
  assign sts_o.period_zero = (word_period == '0);
  assign sts_o.div_last    = (div_cnt_q == {CountW{1'b1}});

  // Restoring division: one quotient bit per cycle
  assign div_shift = {rem_q, quo_q[TimeoutW-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, period_q};
  assign div_ge    = !div_diff[PeriodW+1];

  assign ceil_val = {1'b0, quo_q} + {{(StepsW-1){1'b0}}, (rem_q != '0)};

  // One pattern step on the selected budget
  always_comb begin
    step_src   = cmd_i.finish ? ceil_val : left_q;
    idx_inc    = {1'b0, idx_q} + {{CountW{1'b0}}, 1'b1};
    count_eff  = (count_code_q == '0) ? {1'b1, {CountW{1'b0}}} : {1'b0, count_code_q};
    if (step_src <= {{(StepsW-1){1'b0}}, 1'b1}) begin
      step_left  = '0;
      step_run   = 1'b0;
      step_motor = 1'b0;
      step_idx   = idx_q;
    end else begin
      step_left  = step_src - {{(StepsW-1){1'b0}}, 1'b1};
      step_run   = 1'b1;
      step_motor = mask_q[CountW'(MaskW-1) - idx_q];
      step_idx   = (idx_inc >= count_eff) ? '0 : idx_inc[CountW-1:0];
    end
  end

  assign ms_inc = ms_q + {{(PeriodW-1){1'b0}}, 1'b1};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_in) begin
      code_q    <= cmd_code_i;
      word_q    <= pattern_word_i;
      timeout_q <= timeout_ms_i;
      force_q   <= force_req_i;
      silent_q  <= in_silent_hours_i;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= timeout_q;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_diff[PeriodW-1:0] : div_shift[PeriodW-1:0];
      quo_q <= {quo_q[TimeoutW-2:0], div_ge};
    end
    if (cmd_i.load_out) begin
      out_motor_q <= motor_q;
      out_busy_q  <= run_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q       <= '0;
      count_code_q <= '0;
      period_q     <= '0;
      ms_q         <= '0;
      idx_q        <= '0;
      left_q       <= '0;
      run_q        <= 1'b0;
      motor_q      <= 1'b0;
      div_cnt_q    <= '0;
    end else begin
      if (cmd_i.div_init) begin
        mask_q       <= word_mask;
        count_code_q <= word_count;
        period_q     <= word_period;
        idx_q        <= '0;
        ms_q         <= '0;
        div_cnt_q    <= '0;
      end
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + {{(CountW-1){1'b0}}, 1'b1};
      end
      if (cmd_i.finish) begin
        left_q  <= step_left;
        run_q   <= step_run;
        motor_q <= step_motor;
        idx_q   <= step_idx;
      end
      if (cmd_i.apply) begin
        case (code_q)
          CMD_START: begin
            // zero step length: latch the pattern and stop
            if (sts_o.start_go) begin
              mask_q       <= word_mask;
              count_code_q <= word_count;
              period_q     <= word_period;
              idx_q        <= '0;
              ms_q         <= '0;
              run_q        <= 1'b0;
              motor_q      <= 1'b0;
            end
          end
          CMD_STOP: begin
            run_q   <= 1'b0;
            motor_q <= 1'b0;
          end
          CMD_TICK: begin
            if (run_q) begin
              if (ms_inc >= period_q) begin
                ms_q    <= '0;
                left_q  <= step_left;
                run_q   <= step_run;
                motor_q <= step_motor;
                idx_q   <= step_idx;
              end else begin
                ms_q <= ms_inc;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign motor_on_o = out_motor_q;
  assign busy_res_o = out_busy_q;

endmodule

>>> rtl/vibration_pattern_player_core.sv
// Channel   Dir  tdata (low bit up)                                     tuser
// s_axis    in   pattern_word[31:0] timeout_ms[47:32] force_req[48]     command[1:0]
//                in_silent_hours[49], zero pad [55:50]
// m_axis    out  motor_on[0] busy_res[1], zero pad [7:2]                -
//
// One transaction in, one result out, one item at a time.
// Stop, tick and ignored commands pass from capture through execute to the result register.
// A start with nonzero step length is decoded, then the divider forms ceil(timeout/length)
// one quotient bit at a time, then the first step is played and the result is loaded.
// The result register lets the next input be accepted while a result waits; a stalled
// result holds the next one back. Reset (rst_ni low, asynchronous) stops the motor.
module vibration_pattern_player_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // pattern_word, timeout_ms, force_req, in_silent_hours
  input  logic [vpp_pkg::InDataW-1:0]   s_axis_tdata_i,
  // command
  input  logic [vpp_pkg::CmdW-1:0]      s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // motor_on, busy_res
  output logic [vpp_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import vpp_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    motor_on;
  logic    busy_res;

  // Sequence each transaction through capture, execute or divide and step, and emit
  vpp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // Pattern state, divider and result register
  vpp_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_code_i        (s_axis_tuser_i),
    .pattern_word_i    (s_axis_tdata_i[WordW-1:0]),
    .timeout_ms_i      (s_axis_tdata_i[WordW +: TimeoutW]),
    .force_req_i       (s_axis_tdata_i[WordW+TimeoutW]),
    .in_silent_hours_i (s_axis_tdata_i[WordW+TimeoutW+1]),
    .cmd_i             (dp_cmd),
    .sts_o             (dp_sts),
    .motor_on_o        (motor_on),
    .busy_res_o        (busy_res)
  );

  assign m_axis_tdata_o = {{(OutDataW-2){1'b0}}, busy_res, motor_on};

`ifndef SYNTHESIS
  // Motor may only run while a pattern plays
  a_motor_implies_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (!m_axis_tdata_o[0] || m_axis_tdata_o[1]))
    else $error("motor on while player idle");

  // One item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while an item is in flight");

  // Divider runs only for a start with nonzero step length
  a_div_needs_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.div_init |-> (dp_sts.start_go && !dp_sts.period_zero))
    else $error("division started without a valid step length");
`endif

endmodule
